@@ src/tmcw_pkg.sv @@
// Shared types, constants and the control store of the text console writer.
// No dependencies; every other file imports this package.
`default_nettype none

package tmcw_pkg;

  // Screen geometry defaults
  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  // Fixed codes and values
  localparam logic [2:0] CMD_PUT_CHAR   = 3'd0;
  localparam logic [2:0] CMD_WRITE_CELL = 3'd1;
  localparam logic [2:0] CMD_SET_CURSOR = 3'd2;
  localparam logic [2:0] CMD_READ_CELL  = 3'd3;
  localparam logic [2:0] CMD_CLEAR      = 3'd4;

  localparam int         CFG_IDX_W  = 2;
  localparam int         CFG_DATA_W = 4;
  localparam logic [CFG_IDX_W-1:0] REG_FG_COLOR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BG_COLOR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLINK_ON = 2'd2;

  localparam logic [7:0]  NEWLINE_CHAR = 8'h0A;
  localparam logic [7:0]  BLANK_CHAR   = 8'h20;
  localparam logic [15:0] RESET_CELL   = 16'h0720;
  localparam logic [3:0]  FG_RESET     = 4'h7;

  // Channel words
  typedef struct packed {
    logic [2:0] command;
    logic [7:0] character;
    logic [6:0] column;
    logic [4:0] row;
    logic [7:0] attribute;
  } in_word_t;

  typedef struct packed {
    logic [6:0]  cursor_column;
    logic [4:0]  cursor_row;
    logic [10:0] cursor_offset;
    logic [15:0] cell_value;
    logic        scrolled;
  } out_word_t;

  // Microprogram steps
  typedef enum logic [4:0] {
    ST_RST_INIT,
    ST_RST_FILL,
    ST_IDLE,
    ST_DISPATCH,
    ST_PUT_SEL,
    ST_PUT_WR,
    ST_NEWLINE,
    ST_ROW_CHECK,
    ST_SCROLL_INIT,
    ST_SCROLL_RD,
    ST_SCROLL_WR,
    ST_FILL,
    ST_WRITE_CELL,
    ST_SET_CURSOR,
    ST_READ_RD,
    ST_READ_CAP,
    ST_CLEAR_INIT,
    ST_FINISH
  } step_t;

  // Control word fields
  typedef enum logic [1:0] {MEM_NONE, MEM_READ, MEM_WRITE} mem_op_t;
  typedef enum logic [1:0] {ADDR_PTR, ADDR_PTR_NEXT_ROW, ADDR_CURSOR, ADDR_INPUT} addr_sel_t;
  typedef enum logic [2:0] {WD_RESET, WD_PUT, WD_CELL, WD_BLANK, WD_COPY} wd_sel_t;
  typedef enum logic [1:0] {PTR_HOLD, PTR_CLEAR, PTR_INC} ptr_op_t;
  typedef enum logic [2:0] {CUR_HOLD, CUR_ADVANCE, CUR_NEWLINE, CUR_PARK, CUR_SET} cur_op_t;
  typedef enum logic [2:0] {
    COND_ALWAYS,
    COND_IN_ACCEPT,
    COND_NEWLINE,
    COND_ROW_OVER,
    COND_COPY_END,
    COND_PTR_END,
    COND_OUT_FREE,
    COND_DISPATCH
  } cond_t;

  typedef struct packed {
    logic      take_in;
    mem_op_t   mem_op;
    addr_sel_t addr_sel;
    wd_sel_t   wd_sel;
    ptr_op_t   ptr_op;
    cur_op_t   cur_op;
    logic      set_scrolled;
    logic      cap_cell;
    logic      load_out;
    cond_t     cond;
    step_t     jump_t;
    step_t     jump_f;
  } ctrl_t;

  // Datapath status seen by the sequencer
  typedef struct packed {
    logic       in_accept;
    logic       newline;
    logic       row_over;
    logic       copy_end;
    logic       ptr_end;
    logic       out_free;
    logic [2:0] command;
  } flags_t;

  // Control store: one word per step
  function automatic ctrl_t ucode(step_t s);
    ctrl_t c;
    c = '0;
    case (s)
      ST_RST_INIT: begin
        c.ptr_op = PTR_CLEAR;
        c.jump_t = ST_RST_FILL;
      end
      ST_RST_FILL: begin
        c.mem_op   = MEM_WRITE;
        c.addr_sel = ADDR_PTR;
        c.wd_sel   = WD_RESET;
        c.ptr_op   = PTR_INC;
        c.cond     = COND_PTR_END;
        c.jump_t   = ST_IDLE;
        c.jump_f   = ST_RST_FILL;
      end
      ST_IDLE: begin
        c.take_in = 1'b1;
        c.cond    = COND_IN_ACCEPT;
        c.jump_t  = ST_DISPATCH;
        c.jump_f  = ST_IDLE;
      end
      ST_DISPATCH: begin
        c.cond = COND_DISPATCH;
      end
      ST_PUT_SEL: begin
        c.cond   = COND_NEWLINE;
        c.jump_t = ST_NEWLINE;
        c.jump_f = ST_PUT_WR;
      end
      ST_PUT_WR: begin
        c.mem_op   = MEM_WRITE;
        c.addr_sel = ADDR_CURSOR;
        c.wd_sel   = WD_PUT;
        c.cur_op   = CUR_ADVANCE;
        c.jump_t   = ST_ROW_CHECK;
      end
      ST_NEWLINE: begin
        c.cur_op = CUR_NEWLINE;
        c.jump_t = ST_ROW_CHECK;
      end
      ST_ROW_CHECK: begin
        c.cond   = COND_ROW_OVER;
        c.jump_t = ST_SCROLL_INIT;
        c.jump_f = ST_FINISH;
      end
      ST_SCROLL_INIT: begin
        c.ptr_op       = PTR_CLEAR;
        c.cur_op       = CUR_PARK;
        c.set_scrolled = 1'b1;
        c.jump_t       = ST_SCROLL_RD;
      end
      ST_SCROLL_RD: begin
        c.mem_op   = MEM_READ;
        c.addr_sel = ADDR_PTR_NEXT_ROW;
        c.jump_t   = ST_SCROLL_WR;
      end
      ST_SCROLL_WR: begin
        c.mem_op   = MEM_WRITE;
        c.addr_sel = ADDR_PTR;
        c.wd_sel   = WD_COPY;
        c.ptr_op   = PTR_INC;
        c.cond     = COND_COPY_END;
        c.jump_t   = ST_FILL;
        c.jump_f   = ST_SCROLL_RD;
      end
      ST_FILL: begin
        c.mem_op   = MEM_WRITE;
        c.addr_sel = ADDR_PTR;
        c.wd_sel   = WD_BLANK;
        c.ptr_op   = PTR_INC;
        c.cond     = COND_PTR_END;
        c.jump_t   = ST_FINISH;
        c.jump_f   = ST_FILL;
      end
      ST_WRITE_CELL: begin
        c.mem_op   = MEM_WRITE;
        c.addr_sel = ADDR_INPUT;
        c.wd_sel   = WD_CELL;
        c.jump_t   = ST_FINISH;
      end
      ST_SET_CURSOR: begin
        c.cur_op = CUR_SET;
        c.jump_t = ST_FINISH;
      end
      ST_READ_RD: begin
        c.mem_op   = MEM_READ;
        c.addr_sel = ADDR_INPUT;
        c.jump_t   = ST_READ_CAP;
      end
      ST_READ_CAP: begin
        c.cap_cell = 1'b1;
        c.jump_t   = ST_FINISH;
      end
      ST_CLEAR_INIT: begin
        c.ptr_op = PTR_CLEAR;
        c.jump_t = ST_FILL;
      end
      ST_FINISH: begin
        c.load_out = 1'b1;
        c.cond     = COND_OUT_FREE;
        c.jump_t   = ST_IDLE;
        c.jump_f   = ST_FINISH;
      end
      default: begin
        c.jump_t = ST_RST_INIT;
      end
    endcase
    return c;
  endfunction

  // Entry step for each command
  function automatic step_t dispatch(logic [2:0] cmd);
    step_t s;
    case (cmd)
      CMD_PUT_CHAR:   s = ST_PUT_SEL;
      CMD_WRITE_CELL: s = ST_WRITE_CELL;
      CMD_SET_CURSOR: s = ST_SET_CURSOR;
      CMD_READ_CELL:  s = ST_READ_RD;
      CMD_CLEAR:      s = ST_CLEAR_INIT;
      default:        s = ST_FINISH;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

@@ src/tmcw_seq.sv @@
// Microprogram sequencer: step counter, control store lookup and jump logic.
// Depends on tmcw_pkg for the step, control word and flag types.
`default_nettype none

module tmcw_seq (
  input  wire               clk,
  input  wire               rst_n,
  input  tmcw_pkg::flags_t  flags,
  output tmcw_pkg::ctrl_t   ctrl
);
  import tmcw_pkg::*;

  step_t step_r, step_nxt;
  logic  taken;

  // Look up the control word of the current step
  assign ctrl = ucode(step_r);

  // Resolve the jump condition
  always_comb begin
    case (ctrl.cond)
      COND_ALWAYS:    taken = 1'b1;
      COND_IN_ACCEPT: taken = flags.in_accept;
      COND_NEWLINE:   taken = flags.newline;
      COND_ROW_OVER:  taken = flags.row_over;
      COND_COPY_END:  taken = flags.copy_end;
      COND_PTR_END:   taken = flags.ptr_end;
      COND_OUT_FREE:  taken = flags.out_free;
      default:        taken = 1'b0;
    endcase
    if (ctrl.cond == COND_DISPATCH) begin
      step_nxt = dispatch(flags.command);
    end else if (taken) begin
      step_nxt = ctrl.jump_t;
    end else begin
      step_nxt = ctrl.jump_f;
    end
  end

  // Advance the step counter; reset starts the clearing pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= ST_RST_INIT;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

`default_nettype wire

@@ src/text_mode_console_writer.sv @@
// Top level of the text console writer: screen memory, cursor, config and output word.
// Depends on tmcw_pkg and on tmcw_seq, which steps the control program.
//
//   channel | direction | handshake          | word
//   in_     | input     | in_valid/in_stall   | tmcw_pkg::in_word_t
//   out_    | output    | out_valid/out_stall | tmcw_pkg::out_word_t
//   cfg_    | input     | cfg_we              | cfg_index, cfg_wdata
//
// One word at a time: the next word is accepted only once the last one is finished.
//   The single-port screen memory handles one cell per cycle, and a scroll needs
//   a read and a write for each cell that it moves.
// After reset, a clearing pass writes 0x0720 to every cell with in_stall high.
// A held result does not block the next accept; it stalls only the finish step.
`default_nettype none

module text_mode_console_writer #(
  parameter int COLUMNS = tmcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tmcw_pkg::ROWS_DEF
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 in_valid,
  output logic                                in_stall,
  input  tmcw_pkg::in_word_t                  in_data,
  output logic                                out_valid,
  input  wire                                 out_stall,
  output tmcw_pkg::out_word_t                 out_data,
  input  wire                                 cfg_we,
  input  wire [tmcw_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire [tmcw_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import tmcw_pkg::*;

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(COLUMNS);
  localparam int RW    = $clog2(ROWS + 1);

  ctrl_t  ctrl;
  flags_t flags;

  // Config registers
  logic [3:0] fg_color_r;
  logic [2:0] bg_color_r;
  logic       blink_on_r;
  logic [7:0] cur_attr;

  // Datapath registers
  in_word_t        in_r;
  logic [CW-1:0]   cursor_col_r, cursor_col_nxt;
  logic [RW-1:0]   cursor_row_r, cursor_row_nxt;
  logic [AW-1:0]   ptr_r, ptr_nxt;
  logic [15:0]     cell_r;
  logic            scrolled_r;
  logic            out_valid_r;
  out_word_t       out_data_r;

  // Screen memory
  logic [15:0]     mem [CELLS];
  logic [15:0]     rdata_r;
  logic [AW-1:0]   mem_addr;
  logic [15:0]     mem_wdata;
  logic            mem_we;
  logic            mem_re;

  logic            in_accept;
  logic            out_free;
  logic            in_range;
  logic [AW-1:0]   cur_addr;
  logic [AW-1:0]   in_addr;

  tmcw_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .ctrl  (ctrl)
  );

  // Handshakes
  assign in_stall  = !ctrl.take_in;
  assign in_accept = in_valid && ctrl.take_in;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Addresses and range check
  assign cur_attr = {blink_on_r, bg_color_r, fg_color_r};
  assign cur_addr = AW'(32'(cursor_row_r) * COLUMNS + 32'(cursor_col_r));
  assign in_addr  = AW'(32'(in_r.row) * COLUMNS + 32'(in_r.column));
  assign in_range = (32'(in_r.column) < COLUMNS) && (32'(in_r.row) < ROWS);

  // Status for the sequencer
  always_comb begin
    flags.in_accept = in_accept;
    flags.newline   = (in_r.character == NEWLINE_CHAR);
    flags.row_over  = (cursor_row_r == RW'(ROWS));
    flags.copy_end  = (ptr_r == AW'(CELLS - COLUMNS - 1));
    flags.ptr_end   = (ptr_r == AW'(CELLS - 1));
    flags.out_free  = out_free;
    flags.command   = in_r.command;
  end

  // Memory address and write data
  always_comb begin
    case (ctrl.addr_sel)
      ADDR_PTR:          mem_addr = ptr_r;
      ADDR_PTR_NEXT_ROW: mem_addr = ptr_r + AW'(COLUMNS);
      ADDR_CURSOR:       mem_addr = cur_addr;
      ADDR_INPUT:        mem_addr = in_addr;
      default:           mem_addr = ptr_r;
    endcase
    case (ctrl.wd_sel)
      WD_RESET: mem_wdata = RESET_CELL;
      WD_PUT:   mem_wdata = {cur_attr, in_r.character};
      WD_CELL:  mem_wdata = {in_r.attribute, in_r.character};
      WD_BLANK: mem_wdata = {cur_attr, BLANK_CHAR};
      WD_COPY:  mem_wdata = rdata_r;
      default:  mem_wdata = RESET_CELL;
    endcase
    // drop direct writes that fall outside the screen
    mem_we = (ctrl.mem_op == MEM_WRITE) && ((ctrl.addr_sel != ADDR_INPUT) || in_range);
    mem_re = (ctrl.mem_op == MEM_READ);
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_r <= mem[mem_addr];
    end
  end

  // Pointer and cursor next values
  always_comb begin
    case (ctrl.ptr_op)
      PTR_CLEAR: ptr_nxt = '0;
      PTR_INC:   ptr_nxt = ptr_r + AW'(1);
      default:   ptr_nxt = ptr_r;
    endcase
    cursor_col_nxt = cursor_col_r;
    cursor_row_nxt = cursor_row_r;
    case (ctrl.cur_op)
      CUR_ADVANCE: begin
        if (cursor_col_r == CW'(COLUMNS - 1)) begin
          cursor_col_nxt = '0;
          cursor_row_nxt = cursor_row_r + RW'(1);
        end else begin
          cursor_col_nxt = cursor_col_r + CW'(1);
        end
      end
      CUR_NEWLINE: begin
        cursor_col_nxt = '0;
        cursor_row_nxt = cursor_row_r + RW'(1);
      end
      CUR_PARK: begin
        cursor_row_nxt = RW'(ROWS - 1);
      end
      CUR_SET: begin
        // saturate to the last column and row
        cursor_col_nxt = (32'(in_r.column) < COLUMNS) ? CW'(in_r.column) : CW'(COLUMNS - 1);
        cursor_row_nxt = (32'(in_r.row) < ROWS) ? RW'(in_r.row) : RW'(ROWS - 1);
      end
      default: begin
        cursor_col_nxt = cursor_col_r;
      end
    endcase
  end

  // Control state: config, cursor, output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fg_color_r   <= FG_RESET;
      bg_color_r   <= '0;
      blink_on_r   <= 1'b0;
      cursor_col_r <= '0;
      cursor_row_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_FG_COLOR: fg_color_r <= cfg_wdata[3:0];
          REG_BG_COLOR: bg_color_r <= cfg_wdata[2:0];
          REG_BLINK_ON: blink_on_r <= cfg_wdata[0];
          default:      fg_color_r <= fg_color_r;
        endcase
      end
      cursor_col_r <= cursor_col_nxt;
      cursor_row_r <= cursor_row_nxt;
      if (ctrl.load_out && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload: input word, pointer, read result, output word
  always_ff @(posedge clk) begin
    ptr_r <= ptr_nxt;
    if (in_accept) begin
      in_r       <= in_data;
      cell_r     <= '0;
      scrolled_r <= 1'b0;
    end else begin
      if (ctrl.set_scrolled) begin
        scrolled_r <= 1'b1;
      end
      if (ctrl.cap_cell) begin
        cell_r <= in_range ? rdata_r : '0;
      end
    end
    if (ctrl.load_out && out_free) begin
      out_data_r.cursor_column <= 7'(cursor_col_r);
      out_data_r.cursor_row    <= 5'(cursor_row_r);
      out_data_r.cursor_offset <= 11'(cur_addr);
      out_data_r.cell_value    <= cell_r;
      out_data_r.scrolled      <= scrolled_r;
    end
  end

endmodule

`default_nettype wire

@@ src/tmcw_checker.sv @@
// Port-level checks on the text console writer, bound to its top level.
// Depends on tmcw_pkg for the channel word types.
`default_nettype none

module tmcw_checker #(
  parameter int COLUMNS = tmcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tmcw_pkg::ROWS_DEF
) (
  input wire                 clk,
  input wire                 rst_n,
  input wire                 in_valid,
  input wire                 in_stall,
  input tmcw_pkg::in_word_t  in_data,
  input wire                 out_valid,
  input wire                 out_stall,
  input tmcw_pkg::out_word_t out_data
);
  import tmcw_pkg::*;

  // Hold a stalled input word
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("stalled input changed");

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // Stall input during the clearing pass that follows reset
  a_reset_stall: assert property (@(posedge clk)
    !rst_n |=> in_stall)
    else $error("input taken right after reset");

  // A scroll leaves the cursor on the last row
  a_scroll_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.scrolled |-> out_data.cursor_row == 5'(ROWS - 1))
    else $error("scroll left cursor off the last row");

  // Offset matches row and column
  a_offset: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (ROWS <= 32) |->
      out_data.cursor_offset ==
        11'(32'(out_data.cursor_row) * COLUMNS + 32'(out_data.cursor_column)))
    else $error("cursor offset mismatch");

endmodule

bind text_mode_console_writer tmcw_checker #(
  .COLUMNS (COLUMNS),
  .ROWS    (ROWS)
) u_tmcw_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire

@@ tb/sv/tb_text_mode_console_writer.sv @@
// Self-checking testbench for text_mode_console_writer: driver, monitor and screen predictor.
// Depends on tmcw_pkg for the channel words, command codes and register indexes.
`timescale 1ns / 100ps

module tb_text_mode_console_writer;
  import tmcw_pkg::*;

  localparam int SCR_COLS  = COLUMNS_DEF;
  localparam int SCR_ROWS  = ROWS_DEF;
  localparam int SCR_CELLS = SCR_COLS * SCR_ROWS;
  localparam int PHASE_WORDS = 350;
  localparam int SQUEEZE_CYCLES = 400;
  // Rough worst-case cycles per word: a scroll, a full clear, anything else
  localparam int COST_SCROLL = 4000;
  localparam int COST_CLEAR  = 2010;
  localparam int COST_PLAIN  = 10;
  localparam int COST_SLACK  = 200;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_word_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_word_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // Words waiting to be sent and results waiting to arrive
  in_word_t  pending_words[$];
  out_word_t expected_results[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  logic squeeze_req = 1'b0;
  logic squeeze_done = 1'b0;
  int hold_left = 0;
  int err_cnt = 0;
  int cycle_cnt = 0;
  int work_budget = 0;

  // Predicted screen, cursor and color registers
  logic [15:0] screen_img [0:SCR_CELLS-1];
  int cur_col = 0;
  int cur_row = 0;
  logic [3:0] fg_q = FG_RESET;
  logic [2:0] bg_q = '0;
  logic blink_q = 1'b0;

  text_mode_console_writer u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  function automatic logic [7:0] attr_now();
    return {blink_q, bg_q, fg_q};
  endfunction

  // Fill a run of cells with blanks in the current colors
  function automatic void blank_cells(int first, int count);
    for (int i = first; i < first + count; i++) begin
      screen_img[i] = {attr_now(), BLANK_CHAR};
    end
  endfunction

  // Apply one word to the predicted console and return the result it should produce
  function automatic out_word_t console_apply(in_word_t w);
    out_word_t r;
    logic on_screen;
    r = '0;
    on_screen = (int'(w.column) < SCR_COLS) && (int'(w.row) < SCR_ROWS);
    case (w.command)
      CMD_PUT_CHAR: begin
        if (w.character == NEWLINE_CHAR) begin
          cur_col = 0;
          cur_row++;
        end else begin
          screen_img[cur_row * SCR_COLS + cur_col] = {attr_now(), w.character};
          cur_col++;
          if (cur_col >= SCR_COLS) begin
            cur_col = 0;
            cur_row++;
          end
        end
        // Scroll up one line once the cursor leaves the bottom row
        if (cur_row >= SCR_ROWS) begin
          for (int i = 0; i < SCR_CELLS - SCR_COLS; i++) begin
            screen_img[i] = screen_img[i + SCR_COLS];
          end
          blank_cells(SCR_CELLS - SCR_COLS, SCR_COLS);
          cur_row = SCR_ROWS - 1;
          r.scrolled = 1'b1;
        end
      end
      CMD_WRITE_CELL: begin
        if (on_screen) begin
          screen_img[int'(w.row) * SCR_COLS + int'(w.column)] = {w.attribute, w.character};
        end
      end
      CMD_SET_CURSOR: begin
        cur_col = (int'(w.column) < SCR_COLS) ? int'(w.column) : SCR_COLS - 1;
        cur_row = (int'(w.row) < SCR_ROWS) ? int'(w.row) : SCR_ROWS - 1;
      end
      CMD_READ_CELL: begin
        if (on_screen) begin
          r.cell_value = screen_img[int'(w.row) * SCR_COLS + int'(w.column)];
        end
      end
      CMD_CLEAR: begin
        blank_cells(0, SCR_CELLS);
      end
      default: begin
      end
    endcase
    r.cursor_column = cur_col[6:0];
    r.cursor_row    = cur_row[4:0];
    r.cursor_offset = 11'(cur_row * SCR_COLS + cur_col);
    return r;
  endfunction

  task automatic report_err(string msg);
    $display("%0t: mismatch: %s", $time, msg);
    err_cnt++;
  endtask

  // Queue a word and grow the run limit by its worst-case cost
  task automatic queue_word(in_word_t w);
    pending_words.push_back(w);
    if (w.command == CMD_PUT_CHAR) begin
      work_budget += COST_SCROLL + COST_SLACK;
    end else if (w.command == CMD_CLEAR) begin
      work_budget += COST_CLEAR + COST_SLACK;
    end else begin
      work_budget += COST_PLAIN + COST_SLACK;
    end
  endtask

  function automatic in_word_t make_word(logic [2:0] cmd, logic [7:0] ch, logic [6:0] col,
                                         logic [4:0] row, logic [7:0] attr);
    in_word_t w;
    w.command   = cmd;
    w.character = ch;
    w.column    = col;
    w.row       = row;
    w.attribute = attr;
    return w;
  endfunction

  // Mostly text and cell traffic on the screen, with some off-screen coordinates
  function automatic in_word_t random_word();
    in_word_t w;
    int pick;
    w = make_word(3'($urandom_range(7)), 8'($urandom_range(255)), 7'($urandom_range(127)),
                  5'($urandom_range(31)), 8'($urandom_range(255)));
    pick = $urandom_range(99);
    if (pick < 50) begin
      w.command = CMD_PUT_CHAR;
      if ($urandom_range(99) < 8) w.character = NEWLINE_CHAR;
    end else if (pick < 63) begin
      w.command = CMD_WRITE_CELL;
    end else if (pick < 73) begin
      w.command = CMD_SET_CURSOR;
    end else if (pick < 92) begin
      w.command = CMD_READ_CELL;
    end else if (pick < 94) begin
      w.command = CMD_CLEAR;
    end else begin
      w.command = CMD_CLEAR + 3'($urandom_range(1, 3));
    end
    if ($urandom_range(99) < 85) begin
      w.column = 7'($urandom_range(SCR_COLS - 1));
      w.row    = 5'($urandom_range(SCR_ROWS - 1));
    end
    // Park the cursor on the bottom row now and then so newlines and wraps scroll
    if (w.command == CMD_SET_CURSOR && $urandom_range(99) < 30) begin
      w.row = 5'(SCR_ROWS - 1);
      if ($urandom_range(1) == 1) w.column = 7'(SCR_COLS - 1 - $urandom_range(3));
    end
    return w;
  endfunction

  // Wait until every word is sent and every result is back, then let the block settle
  task automatic settle();
    while (pending_words.size() != 0 || in_valid || expected_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (16) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_FG_COLOR: fg_q = val[3:0];
      REG_BG_COLOR: bg_q = val[2:0];
      REG_BLINK_ON: blink_q = val[0];
      default: begin
      end
    endcase
  endtask

  task automatic set_colors(logic [3:0] fg, logic [3:0] bg, logic [3:0] blink);
    write_reg(REG_FG_COLOR, fg);
    write_reg(REG_BG_COLOR, bg);
    write_reg(REG_BLINK_ON, blink);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(int send_pct, int recv_pct, logic squeeze);
    @(negedge clk);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    squeeze_req    = squeeze;
    for (int i = 0; i < PHASE_WORDS; i++) begin
      queue_word(random_word());
    end
    settle();
  endtask

  // Driver: hold a stalled word, else offer the next pending one unless idling
  always @(posedge clk) begin : drive_words
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(console_apply(in_data));
      end
      if (in_valid && in_stall) begin
        in_valid <= 1'b1;
      end else if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_data  <= pending_words.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off when requested
  always @(posedge clk) begin : drive_stall
    int hold_next;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (squeeze_req && !squeeze_done) begin
        hold_next = SQUEEZE_CYCLES;
        squeeze_done <= 1'b1;
      end else if (hold_left > 0) begin
        hold_next = hold_left - 1;
      end else begin
        hold_next = 0;
      end
      hold_left <= hold_next;
      out_stall <= (hold_next > 0) || ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Monitor: compare each accepted result with the oldest prediction
  always @(posedge clk) begin : watch_results
    out_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        report_err("result word with nothing expected");
      end else begin
        want = expected_results.pop_front();
        if (out_data.cursor_column != want.cursor_column)
          report_err($sformatf("cursor_column got %0d want %0d",
                               out_data.cursor_column, want.cursor_column));
        if (out_data.cursor_row != want.cursor_row)
          report_err($sformatf("cursor_row got %0d want %0d",
                               out_data.cursor_row, want.cursor_row));
        if (out_data.cursor_offset != want.cursor_offset)
          report_err($sformatf("cursor_offset got %0d want %0d",
                               out_data.cursor_offset, want.cursor_offset));
        if (out_data.cell_value != want.cell_value)
          report_err($sformatf("cell_value got %h want %h",
                               out_data.cell_value, want.cell_value));
        if (out_data.scrolled != want.scrolled)
          report_err($sformatf("scrolled got %0d want %0d",
                               out_data.scrolled, want.scrolled));
      end
    end
  end

  // Watchdog: the limit covers the clearing pass and the worst case of every queued word
  always @(posedge clk) begin : watchdog
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > 4 * work_budget + 20000) begin
      $display("tb_text_mode_console_writer: errors");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < SCR_CELLS; i++) begin
      screen_img[i] = RESET_CELL;
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed words with the reset colors
    @(negedge clk);
    queue_word(make_word(CMD_READ_CELL, 8'h00, 7'd0, 5'd0, 8'h00));
    queue_word(make_word(CMD_READ_CELL, 8'h00, 7'd79, 5'd24, 8'h00));
    queue_word(make_word(CMD_PUT_CHAR, 8'h48, 7'd0, 5'd0, 8'h00));
    queue_word(make_word(CMD_PUT_CHAR, 8'h00, 7'd0, 5'd0, 8'h00));
    queue_word(make_word(CMD_PUT_CHAR, 8'hFF, 7'd127, 5'd31, 8'hFF));
    queue_word(make_word(CMD_PUT_CHAR, NEWLINE_CHAR, 7'd0, 5'd0, 8'h00));
    queue_word(make_word(CMD_WRITE_CELL, 8'hFF, 7'd79, 5'd24, 8'hFF));
    queue_word(make_word(CMD_WRITE_CELL, 8'h00, 7'd0, 5'd0, 8'h00));
    queue_word(make_word(CMD_WRITE_CELL, 8'h55, 7'd80, 5'd0, 8'h1E));
    queue_word(make_word(CMD_WRITE_CELL, 8'hAA, 7'd127, 5'd31, 8'hE1));
    queue_word(make_word(CMD_READ_CELL, 8'h00, 7'd79, 5'd24, 8'h00));
    queue_word(make_word(CMD_READ_CELL, 8'h00, 7'd127, 5'd31, 8'h00));
    queue_word(make_word(CMD_READ_CELL, 8'h00, 7'd0, 5'd25, 8'h00));
    // Saturate the cursor, then wrap off the bottom right corner into a scroll
    queue_word(make_word(CMD_SET_CURSOR, 8'h00, 7'd127, 5'd31, 8'h00));
    queue_word(make_word(CMD_PUT_CHAR, 8'h5A, 7'd0, 5'd0, 8'h00));
    queue_word(make_word(CMD_READ_CELL, 8'h00, 7'd79, 5'd23, 8'h00));
    queue_word(make_word(CMD_READ_CELL, 8'h00, 7'd0, 5'd24, 8'h00));
    queue_word(make_word(CMD_PUT_CHAR, NEWLINE_CHAR, 7'd0, 5'd0, 8'h00));
    queue_word(make_word(CMD_CLEAR + 3'd1, 8'hFF, 7'd127, 5'd31, 8'hFF));
    queue_word(make_word(CMD_CLEAR + 3'd2, 8'h00, 7'd0, 5'd0, 8'h00));
    queue_word(make_word(CMD_CLEAR + 3'd3, 8'h0A, 7'd79, 5'd24, 8'h00));
    queue_word(make_word(CMD_CLEAR, 8'h00, 7'd0, 5'd0, 8'h00));
    settle();

    // All color bits set: text and blanks pick up the new attribute
    set_colors(4'hF, 4'h7, 4'h1);
    @(negedge clk);
    queue_word(make_word(CMD_PUT_CHAR, 8'h41, 7'd0, 5'd0, 8'h00));
    queue_word(make_word(CMD_CLEAR, 8'h00, 7'd0, 5'd0, 8'h00));
    queue_word(make_word(CMD_READ_CELL, 8'h00, 7'd40, 5'd12, 8'h00));
    settle();

    // Random traffic: sender-light idling, then receiver-light, then none with a hold-off
    set_colors(4'($urandom_range(15)), 4'($urandom_range(15)), 4'($urandom_range(15)));
    run_phase(32, 88, 1'b0);
    set_colors(4'h0, 4'h0, 4'h0);
    run_phase(88, 32, 1'b0);
    set_colors(4'($urandom_range(15)), 4'($urandom_range(15)), 4'($urandom_range(15)));
    run_phase(0, 0, 1'b1);

    if (err_cnt == 0) begin
      $display("tb_text_mode_console_writer: clean");
    end else begin
      $display("tb_text_mode_console_writer: errors");
    end
    $finish;
  end

endmodule
